/* design/line_clipper_liang_barsky_top_macros.svh */
`ifndef LINE_CLIPPER_LIANG_BARSKY_TOP_MACROS_SVH
`define LINE_CLIPPER_LIANG_BARSKY_TOP_MACROS_SVH

// check pre implies post in the same cycle
`define LCLB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lclb check failed");

// check pre implies post in the next cycle
`define LCLB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lclb check failed");

`endif

/* design/lclb_pkg.sv */
`timescale 1ns / 1ps

package lclb_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int REG_W       = 13;
  localparam int REG_INDEX_W = 1;

  localparam logic [REG_W-1:0] VIEWPORT_WIDTH_RST = 13'd320;
  localparam logic [REG_W-1:0] BAND_HEIGHT_RST    = 13'd240;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_VIEWPORT_WIDTH = 1'b0,
    REG_BAND_HEIGHT    = 1'b1
  } reg_index_t;

endpackage

/* design/lclb_line_if.sv */
`timescale 1ns / 1ps

interface lclb_line_if #(
  parameter int COORD_BITS = lclb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source(output valid, x_start, y_start, x_end, y_end, input ready);
  modport sink(input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lclb_clip_if #(
  parameter int COORD_BITS = lclb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clip_x_start;
  logic signed [COORD_BITS-1:0] clip_y_start;
  logic signed [COORD_BITS-1:0] clip_x_end;
  logic signed [COORD_BITS-1:0] clip_y_end;

  modport source(output valid, visible, clip_x_start, clip_y_start, clip_x_end, clip_y_end,
                 input ready);
  modport sink(input valid, visible, clip_x_start, clip_y_start, clip_x_end, clip_y_end,
               output ready);
endinterface

/* design/line_clipper_liang_barsky_top.sv */
`timescale 1ns / 1ps
// Liang-Barsky line clipper against the rectangle 0..width-1 by 0..height-1.
// line_in takes one word per line (x_start, y_start, x_end, y_end); line_out
// returns one word per line (visible and the clipped endpoints, all zero when
// the line is rejected). Both use valid/ready; a word moves when both are high.
// cfg_we/cfg_index/cfg_wdata write viewport_width (index 0) and band_height
// (index 1); write them only while no line is in flight.
// Throughput: one line per cycle while line_out does not stall. Each line passes an
// input stage, four pipelined restoring dividers that retire one quotient bit per
// stage, a t0/t1 resolve stage, a multiply stage and the output register.
// Reset clears every stage valid bit and loads width 320, height 240.
// When line_out stalls, the whole pipeline holds and line_in.ready drops;
// nothing is lost or repeated.
`include "line_clipper_liang_barsky_top_macros.svh"

module line_clipper_liang_barsky_top #(
  parameter int COORD_BITS    = lclb_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = lclb_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lclb_line_if.sink                     line_in,
  lclb_clip_if.source                   line_out,
  input  logic                          cfg_we,
  input  logic [lclb_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [lclb_pkg::REG_W-1:0]    cfg_wdata
);
  import lclb_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int FW  = FRACTION_BITS;
  localparam int PW  = CW + 1;
  localparam int QW  = ((CW > REG_W) ? CW : REG_W) + 2;
  localparam int MW  = QW - 1 + FW;
  localparam int RW  = MW + 1;
  localparam int PRW = FW + 2 + PW;

  typedef struct packed {
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] dy;
    logic [3:0]           pz;
    logic [3:0]           qneg;
    logic [3:0]           pneg;
  } side_t;

  logic [REG_W-1:0] viewport_width;
  logic [REG_W-1:0] band_height;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width <= VIEWPORT_WIDTH_RST;
      band_height    <= BAND_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEWPORT_WIDTH: viewport_width <= cfg_wdata;
        REG_BAND_HEIGHT:    band_height    <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  assign en            = !line_out.valid || line_out.ready;
  assign line_in.ready = en;

  logic signed [QW-1:0] a_q    [4];
  logic signed [PW-1:0] a_p    [4];
  logic [QW-2:0]        a_qmag [4];
  logic [PW-1:0]        a_pmag [4];
  logic signed [PW-1:0] a_dx;
  logic signed [PW-1:0] a_dy;
  logic signed [QW-1:0] a_xs;
  logic signed [QW-1:0] a_ys;
  logic signed [QW-1:0] a_qneg_tmp [4];
  logic signed [PW-1:0] a_pneg_tmp [4];

  always_comb begin
    a_xs  = {{(QW-CW){line_in.x_start[CW-1]}}, line_in.x_start};
    a_ys  = {{(QW-CW){line_in.y_start[CW-1]}}, line_in.y_start};
    a_dx  = {line_in.x_end[CW-1], line_in.x_end} - {line_in.x_start[CW-1], line_in.x_start};
    a_dy  = {line_in.y_end[CW-1], line_in.y_end} - {line_in.y_start[CW-1], line_in.y_start};
    a_p[0] = -a_dx;
    a_p[1] = a_dx;
    a_p[2] = -a_dy;
    a_p[3] = a_dy;
    a_q[0] = a_xs;
    a_q[1] = {{(QW-REG_W){1'b0}}, viewport_width} - QW'(1) - a_xs;
    a_q[2] = a_ys;
    a_q[3] = {{(QW-REG_W){1'b0}}, band_height} - QW'(1) - a_ys;
    for (int l = 0; l < 4; l++) begin
      a_qneg_tmp[l] = -a_q[l];
      a_pneg_tmp[l] = -a_p[l];
      a_qmag[l] = a_q[l][QW-1] ? a_qneg_tmp[l][QW-2:0] : a_q[l][QW-2:0];
      a_pmag[l] = a_p[l][PW-1] ? a_pneg_tmp[l] : a_p[l];
    end
  end

  logic [PW-1:0] dv_rem [0:MW][4];
  logic [MW-1:0] dv_num [0:MW][4];
  logic [MW-1:0] dv_quo [0:MW][4];
  logic [PW-1:0] dv_div [0:MW][4];
  side_t         sd     [0:MW];
  logic          vld_d  [0:MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d[0] <= 1'b0;
    end else if (en) begin
      vld_d[0] <= line_in.valid;
    end
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        dv_rem[0][l] <= '0;
        dv_num[0][l] <= {a_qmag[l], {FW{1'b0}}};
        dv_quo[0][l] <= '0;
        dv_div[0][l] <= a_pmag[l];
        sd[0].pz[l]   <= (a_p[l] == '0);
        sd[0].qneg[l] <= a_q[l][QW-1];
        sd[0].pneg[l] <= a_p[l][PW-1];
      end
      sd[0].xs <= line_in.x_start;
      sd[0].ys <= line_in.y_start;
      sd[0].dx <= a_dx;
      sd[0].dy <= a_dy;
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [PW:0] trial [4];
    logic [PW:0] diff  [4];
    logic [3:0]  take;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {dv_rem[k][l], dv_num[k][l][MW-1]};
        diff[l]  = trial[l] - {1'b0, dv_div[k][l]};
        take[l]  = !diff[l][PW];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[k+1] <= 1'b0;
      end else if (en) begin
        vld_d[k+1] <= vld_d[k];
      end
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          dv_rem[k+1][l] <= take[l] ? diff[l][PW-1:0] : trial[l][PW-1:0];
          dv_num[k+1][l] <= {dv_num[k][l][MW-2:0], 1'b0};
          dv_quo[k+1][l] <= {dv_quo[k][l][MW-2:0], take[l]};
          dv_div[k+1][l] <= dv_div[k][l];
        end
        sd[k+1] <= sd[k];
      end
    end
  end

  localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

  logic signed [RW-1:0] rs_r  [4];
  logic signed [RW-1:0] rs_t0x;
  logic signed [RW-1:0] rs_t1x;
  logic [FW:0]          rs_t0;
  logic [FW:0]          rs_t1;
  logic                 rs_ok;

  always_comb begin
    rs_t0 = '0;
    rs_t1 = ONE;
    rs_ok = 1'b1;
    rs_t0x = '0;
    rs_t1x = '0;
    for (int l = 0; l < 4; l++) begin
      rs_r[l] = (sd[MW].qneg[l] ^ sd[MW].pneg[l]) ? -{1'b0, dv_quo[MW][l]}
                                                   : {1'b0, dv_quo[MW][l]};
      rs_t0x = {{(RW-FW-1){1'b0}}, rs_t0};
      rs_t1x = {{(RW-FW-1){1'b0}}, rs_t1};
      if (rs_ok) begin
        if (sd[MW].pz[l]) begin
          if (sd[MW].qneg[l]) rs_ok = 1'b0;
        end else if (sd[MW].pneg[l]) begin
          if (rs_r[l] > rs_t1x) rs_ok = 1'b0;
          else if (rs_r[l] > rs_t0x) rs_t0 = rs_r[l][FW:0];
        end else begin
          if (rs_r[l] < rs_t0x) rs_ok = 1'b0;
          else if (rs_r[l] < rs_t1x) rs_t1 = rs_r[l][FW:0];
        end
      end
    end
  end

  logic                 vld_r;
  logic                 r_ok;
  logic [FW:0]          r_t0;
  logic [FW:0]          r_t1;
  logic signed [CW-1:0] r_xs;
  logic signed [CW-1:0] r_ys;
  logic signed [PW-1:0] r_dx;
  logic signed [PW-1:0] r_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_d[MW];
    end
    if (en) begin
      r_ok <= rs_ok;
      r_t0 <= rs_t0;
      r_t1 <= rs_t1;
      r_xs <= sd[MW].xs;
      r_ys <= sd[MW].ys;
      r_dx <= sd[MW].dx;
      r_dy <= sd[MW].dy;
    end
  end

  logic signed [FW+1:0] ms_t0;
  logic signed [FW+1:0] ms_dt;
  logic [FW:0]          ms_dt_u;

  always_comb begin
    ms_dt_u = r_t1 - r_t0;
    ms_t0   = {1'b0, r_t0};
    ms_dt   = {1'b0, ms_dt_u};
  end

  logic                  vld_m;
  logic                  m_ok;
  logic signed [PRW-1:0] m_x0;
  logic signed [PRW-1:0] m_y0;
  logic signed [PRW-1:0] m_xd;
  logic signed [PRW-1:0] m_yd;
  logic signed [CW-1:0]  m_xs;
  logic signed [CW-1:0]  m_ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else if (en) begin
      vld_m <= vld_r;
    end
    if (en) begin
      m_ok <= r_ok;
      m_x0 <= ms_t0 * r_dx;
      m_y0 <= ms_t0 * r_dy;
      m_xd <= ms_dt * r_dx;
      m_yd <= ms_dt * r_dy;
      m_xs <= r_xs;
      m_ys <= r_ys;
    end
  end

  function automatic logic [CW-1:0] trunc_fx(input logic signed [PRW-1:0] v);
    logic signed [PRW-1:0] sh;
    logic                  adj;
    sh  = v >>> FW;
    adj = v[PRW-1] && (|v[FW-1:0]);
    return sh[CW-1:0] + CW'(adj);
  endfunction

  logic [CW-1:0] o_x0;
  logic [CW-1:0] o_y0;
  logic [CW-1:0] o_x1;
  logic [CW-1:0] o_y1;

  always_comb begin
    o_x0 = m_xs + trunc_fx(m_x0);
    o_y0 = m_ys + trunc_fx(m_y0);
    o_x1 = o_x0 + trunc_fx(m_xd);
    o_y1 = o_y0 + trunc_fx(m_yd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_out.valid <= 1'b0;
    end else if (en) begin
      line_out.valid <= vld_m;
    end
    if (en) begin
      line_out.visible      <= m_ok;
      line_out.clip_x_start <= m_ok ? o_x0 : '0;
      line_out.clip_y_start <= m_ok ? o_y0 : '0;
      line_out.clip_x_end   <= m_ok ? o_x1 : '0;
      line_out.clip_y_end   <= m_ok ? o_y1 : '0;
    end
  end

  `LCLB_ASSERT_SAME(a_t_order, vld_r && r_ok, r_t0 <= r_t1)
  `LCLB_ASSERT_SAME(a_t1_range, vld_r && r_ok, r_t1 <= ONE)
  `LCLB_ASSERT_NEXT(a_reject_flow, en && vld_m && !m_ok, line_out.valid && !line_out.visible)
  `LCLB_ASSERT_SAME(a_reject_zero, line_out.valid && !line_out.visible,
                    line_out.clip_x_start == '0 && line_out.clip_y_start == '0 &&
                    line_out.clip_x_end == '0 && line_out.clip_y_end == '0)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lclb_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam longint ONE_T = longint'(1) << FB;
  localparam int LATENCY = CB + FB + 5;

  typedef struct packed {
    logic visible;
    logic [CB-1:0] cx0;
    logic [CB-1:0] cy0;
    logic [CB-1:0] cx1;
    logic [CB-1:0] cy1;
  } clip_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = REG_VIEWPORT_WIDTH;
  logic [REG_W-1:0] cfg_wdata = '0;

  lclb_line_if #(.COORD_BITS(CB)) line_in ();
  lclb_clip_if #(.COORD_BITS(CB)) line_out ();

  line_clipper_liang_barsky_top #(.COORD_BITS(CB), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst), .line_in(line_in.sink), .line_out(line_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [REG_W-1:0] clip_width = VIEWPORT_WIDTH_RST;
  logic [REG_W-1:0] clip_height = BAND_HEIGHT_RST;
  clip_word_t clip_queue[$];
  int errors = 0;
  int lines_sent = 0;
  int words_checked = 0;
  int visible_seen = 0;
  int burst_left = 0;

  initial begin
    line_in.valid = 1'b0;
    line_in.x_start = '0;
    line_in.y_start = '0;
    line_in.x_end = '0;
    line_in.y_end = '0;
    line_out.ready = 1'b0;
  end

  function automatic longint scale_trunc(longint t, longint d);
    return (t * d) / ONE_T;
  endfunction

  function automatic clip_word_t clip_line(logic signed [CB-1:0] xs_i,
                                           logic signed [CB-1:0] ys_i,
                                           logic signed [CB-1:0] xe_i,
                                           logic signed [CB-1:0] ye_i);
    longint xs, ys, dx, dy, t0, t1, r, ndx, ndy, cx0, cy0, cx1, cy1;
    longint p[4];
    longint q[4];
    bit ok;
    clip_word_t w;
    xs = xs_i;
    ys = ys_i;
    dx = longint'(xe_i) - xs;
    dy = longint'(ye_i) - ys;
    t0 = 0;
    t1 = ONE_T;
    ok = 1'b1;
    p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
    q[0] = xs;
    q[1] = longint'(clip_width) - 1 - xs;
    q[2] = ys;
    q[3] = longint'(clip_height) - 1 - ys;
    for (int i = 0; i < 4; i++) begin
      if (ok) begin
        if (p[i] == 0) begin
          if (q[i] < 0) ok = 1'b0;
        end else begin
          r = (q[i] * ONE_T) / p[i];
          if (p[i] < 0) begin
            if (r > t1) ok = 1'b0;
            else if (r > t0) t0 = r;
          end else begin
            if (r < t0) ok = 1'b0;
            else if (r < t1) t1 = r;
          end
        end
      end
    end
    w = '0;
    if (ok) begin
      ndx = scale_trunc(t1 - t0, dx);
      ndy = scale_trunc(t1 - t0, dy);
      cx0 = xs + scale_trunc(t0, dx);
      cy0 = ys + scale_trunc(t0, dy);
      cx1 = cx0 + ndx;
      cy1 = cy0 + ndy;
      w.visible = 1'b1;
      w.cx0 = cx0[CB-1:0];
      w.cy0 = cy0[CB-1:0];
      w.cx1 = cx1[CB-1:0];
      w.cy1 = cy1[CB-1:0];
    end
    return w;
  endfunction

  task automatic send_line(logic [CB-1:0] xs, logic [CB-1:0] ys,
                           logic [CB-1:0] xe, logic [CB-1:0] ye);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        line_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    line_in.valid <= 1'b1;
    line_in.x_start <= xs;
    line_in.y_start <= ys;
    line_in.x_end <= xe;
    line_in.y_end <= ye;
    clip_queue.push_back(clip_line(xs, ys, xe, ye));
    do @(posedge clk); while (!line_in.ready);
    lines_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    line_in.valid <= 1'b0;
    while (clip_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [REG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VIEWPORT_WIDTH) clip_width = value;
    else clip_height = value;
    @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord(int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return CB'($urandom());
    if (pick == 1) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    return CB'(int'($urandom_range(0, 2 * span + 40)) - span / 2 - 20);
  endfunction

  task automatic test_directed();
    logic [CB-1:0] lo, hi;
    lo = 16'h8000;
    hi = 16'h7fff;
    send_line(10, 10, 100, 100);
    send_line(-50, 120, 400, 120);
    send_line(160, -30, 160, 300);
    send_line(-10, 5, -10, 200);
    send_line(5, 300, 200, 300);
    send_line(50, 50, 50, 50);
    send_line(500, 50, 500, 50);
    send_line(0, 0, 319, 239);
    send_line(319, 239, 0, 0);
    send_line(lo, lo, hi, hi);
    send_line(hi, hi, lo, lo);
    send_line(lo, hi, hi, lo);
    send_line(lo, lo, lo, lo);
    send_line(hi, hi, hi, hi);
    send_line(-100, 500, 500, -100);
    send_line(400, 10, 300, 10);
    send_line(0, 0, 0, 0);
    send_line(-1, -1, 320, 240);
    send_line(16'hffff, 0, 16'hffff, 16'hffff);
    drain();
  endtask

  task automatic test_random(int count, int span);
    for (int i = 0; i < count; i++)
      send_line(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_VIEWPORT_WIDTH, 1);
    write_reg(REG_BAND_HEIGHT, 1);
    test_random(200, 8);
    write_reg(REG_VIEWPORT_WIDTH, 4096);
    write_reg(REG_BAND_HEIGHT, 4096);
    test_random(300, 4096);
    write_reg(REG_VIEWPORT_WIDTH, 0);
    write_reg(REG_BAND_HEIGHT, 77);
    test_random(100, 100);
    write_reg(REG_VIEWPORT_WIDTH, 13'h1fff);
    write_reg(REG_BAND_HEIGHT, 3);
    test_random(200, 8191);
    write_reg(REG_VIEWPORT_WIDTH, 640);
    write_reg(REG_BAND_HEIGHT, 480);
    test_random(400, 640);
  endtask

  always @(negedge clk) begin
    if (rst) line_out.ready <= 1'b0;
    else if (($time / 2000) % 3 == 0) line_out.ready <= 1'b1;
    else line_out.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    clip_word_t want;
    if (!rst && line_out.valid && line_out.ready) begin
      if (clip_queue.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = clip_queue.pop_front();
        words_checked++;
        if (want.visible) visible_seen++;
        if (line_out.visible !== want.visible) begin
          $error("visible: expected %0d got %0d", want.visible, line_out.visible);
          errors++;
        end
        if (line_out.clip_x_start !== want.cx0) begin
          $error("clip_x_start: expected %0d got %0d", $signed(want.cx0),
                 line_out.clip_x_start);
          errors++;
        end
        if (line_out.clip_y_start !== want.cy0) begin
          $error("clip_y_start: expected %0d got %0d", $signed(want.cy0),
                 line_out.clip_y_start);
          errors++;
        end
        if (line_out.clip_x_end !== want.cx1) begin
          $error("clip_x_end: expected %0d got %0d", $signed(want.cx1), line_out.clip_x_end);
          errors++;
        end
        if (line_out.clip_y_end !== want.cy1) begin
          $error("clip_y_end: expected %0d got %0d", $signed(want.cy1), line_out.clip_y_end);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(700, 320);
    test_settings();
    if (clip_queue.size() != 0) begin
      $error("%0d results never arrived", clip_queue.size());
      errors++;
    end
    $display("Sent %0d lines, checked %0d words, %0d visible,", lines_sent, words_checked,
             visible_seen);
    $display("across default, minimum, maximum, zero and oversized clip rectangles.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
